FILE: design/box_circle_collision_assert.svh
// Assertion macros shared by the checker file.
`ifndef BOX_CIRCLE_COLLISION_ASSERT_SVH
`define BOX_CIRCLE_COLLISION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

FILE: design/bcc_pkg.sv
`timescale 1ns / 1ps
package bcc_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;

  // Datapath widths
  localparam int CFG_W   = 31;
  localparam int DIST_W  = 32;
  localparam int SQ_W    = 64;
  localparam int REM_W   = 35;
  localparam int NRM_W   = 18;
  localparam int DIV_BITS = NRM_W;
  localparam int NUM_W   = 31 + FRAC_BITS;
  localparam int DW      = 64;
  localparam int PROD_W  = NRM_W + 31;
  localparam int SUM_W   = PROD_W + 2;

  // Normal limits: magnitude saturates at 2.0 raw, positive side at 2.0 - lsb
  localparam logic [NRM_W-1:0] NRM_SAT = NRM_W'(131072);
  localparam logic [NRM_W-1:0] NRM_MAX = NRM_W'(131071);
  localparam logic [NRM_W-1:0] NRM_ONE =
    ((1 << FRAC_BITS) > 131071) ? NRM_W'(131071) : NRM_W'(1 << FRAC_BITS);

  // Distances below 1e-5 count as zero: dist * 100000 < 2^FRAC_BITS
  localparam logic [DIST_W-1:0] TINY_LIM =
    DIST_W'(((1 << FRAC_BITS) + 99999) / 100000);

  // Config register indexes
  typedef enum logic [0:0] {
    CFG_BOX_WIDTH  = 1'b0,
    CFG_BOX_HEIGHT = 1'b1
  } cfg_idx_t;

  // Per-request data carried alongside the root and divide pipes
  typedef struct packed {
    logic              hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic              negx;
    logic              negy;
    logic [30:0]       adx;
    logic [30:0]       ady;
    logic [30:0]       rad;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DIST_W-1:0] dlen;
  } div_side_t;

endpackage

FILE: design/bcc_front.sv
`timescale 1ns / 1ps
module bcc_front import bcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] box_x,
  input  logic signed [31:0] box_y,
  input  logic signed [31:0] circle_x,
  input  logic signed [31:0] circle_y,
  input  logic [30:0]        circle_radius,
  input  logic               same_owner,
  input  logic [CFG_W-1:0]   box_width,
  input  logic [CFG_W-1:0]   box_height,
  output logic               out_valid,
  output logic [SQ_W-1:0]    out_dsq,
  output side_t              out_side
);

  // Stage 1: box extent
  logic signed [33:0] bx34, by34, hw34, hh34;
  logic               s1_valid;
  logic signed [33:0] s1_lox, s1_hix, s1_loy, s1_hiy;
  logic signed [31:0] s1_cx, s1_cy;
  logic [30:0]        s1_r;
  logic               s1_same;

  assign bx34 = {{2{box_x[31]}}, box_x};
  assign by34 = {{2{box_y[31]}}, box_y};
  assign hw34 = {4'b0, box_width[30:1]};
  assign hh34 = {4'b0, box_height[30:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lox  <= bx34 - hw34;
      s1_hix  <= bx34 + hw34;
      s1_loy  <= by34 - hh34;
      s1_hiy  <= by34 + hh34;
      s1_cx   <= circle_x;
      s1_cy   <= circle_y;
      s1_r    <= circle_radius;
      s1_same <= same_owner;
    end
  end

  // Stage 2: closest point and offset
  logic signed [33:0] cx34, cy34, tx, ty, clx, cly;
  logic               s2_valid;
  logic signed [31:0] s2_px, s2_py;
  logic signed [33:0] s2_dx, s2_dy;
  logic [30:0]        s2_r;
  logic               s2_same;

  assign cx34 = {{2{s1_cx[31]}}, s1_cx};
  assign cy34 = {{2{s1_cy[31]}}, s1_cy};
  assign tx   = (cx34 < s1_hix) ? cx34 : s1_hix;
  assign ty   = (cy34 < s1_hiy) ? cy34 : s1_hiy;
  assign clx  = (tx > s1_lox) ? tx : s1_lox;
  assign cly  = (ty > s1_loy) ? ty : s1_loy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  // closest always lands inside the 32-bit range
  always_ff @(posedge clk) begin
    if (en) begin
      s2_px   <= clx[31:0];
      s2_py   <= cly[31:0];
      s2_dx   <= cx34 - clx;
      s2_dy   <= cy34 - cly;
      s2_r    <= s1_r;
      s2_same <= s1_same;
    end
  end

  // Stage 3: magnitudes and quick reject
  logic [33:0] magx, magy;
  logic        s3_valid;
  logic        s3_pre;
  side_t       s3_side;

  assign magx = s2_dx[33] ? 34'(-s2_dx) : 34'(s2_dx);
  assign magy = s2_dy[33] ? 34'(-s2_dy) : 34'(s2_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pre       <= !s2_same && (magx <= {3'b0, s2_r}) && (magy <= {3'b0, s2_r});
      s3_side.hit  <= 1'b0;
      s3_side.px   <= s2_px;
      s3_side.py   <= s2_py;
      s3_side.negx <= s2_dx[33];
      s3_side.negy <= s2_dy[33];
      s3_side.adx  <= magx[30:0];
      s3_side.ady  <= magy[30:0];
      s3_side.rad  <= s2_r;
    end
  end

  // Stage 4: squares
  logic        s4_valid;
  logic        s4_pre;
  logic [61:0] s4_sqx, s4_sqy, s4_rsq;
  side_t       s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pre  <= s3_pre;
      s4_sqx  <= s3_side.adx * s3_side.adx;
      s4_sqy  <= s3_side.ady * s3_side.ady;
      s4_rsq  <= s3_side.rad * s3_side.rad;
      s4_side <= s3_side;
    end
  end

  // Stage 5: squared distance and hit decision
  logic [62:0] dsq;
  side_t       s5_side;

  assign dsq = {1'b0, s4_sqx} + {1'b0, s4_sqy};

  always_comb begin
    s5_side     = s4_side;
    s5_side.hit = s4_pre && (dsq <= {1'b0, s4_rsq});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dsq  <= {1'b0, dsq};
      out_side <= s5_side;
    end
  end

endmodule

FILE: design/bcc_sqrt.sv
`timescale 1ns / 1ps
module bcc_sqrt import bcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_val,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_root,
  output side_t             out_side
);

  localparam int STEPS = SQ_W / 2;

  // One root bit per stage, most significant first
  logic              vld  [1:STEPS];
  logic [SQ_W-1:0]   val  [1:STEPS];
  logic [REM_W-1:0]  rem  [1:STEPS];
  logic [DIST_W-1:0] root [1:STEPS];
  side_t             side [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam int LSB = 2 * (STEPS - 1 - i);
    logic              v_in;
    logic [SQ_W-1:0]   val_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [DIST_W-1:0] root_in;
    side_t             side_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign val_in  = in_val;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[i];
      assign val_in  = val[i];
      assign rem_in  = rem[i];
      assign root_in = root[i];
      assign side_in = side[i];
    end

    // bring down two bits, try root*4 + 1
    assign rem_sh = {rem_in[REM_W-3:0], val_in[LSB+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[i+1]  <= val_in;
        rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
        root[i+1] <= {root_in[DIST_W-2:0], ge};
        side[i+1] <= side_in;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = root[STEPS];
  assign out_side  = side[STEPS];

endmodule

FILE: design/bcc_div.sv
`timescale 1ns / 1ps
module bcc_div import bcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIST_W-1:0] in_dist,
  input  side_t             in_side,
  output logic              out_valid,
  output div_side_t         out_side,
  output logic [NRM_W-1:0]  out_qx,
  output logic [NRM_W-1:0]  out_qy,
  output logic              out_ovx,
  output logic              out_ovy
);

  // Restoring divide, one quotient bit per stage, both axes side by side
  logic             vld  [1:DIV_BITS];
  div_side_t        dsd  [1:DIV_BITS];
  logic [DW-1:0]    remx [1:DIV_BITS];
  logic [DW-1:0]    remy [1:DIV_BITS];
  logic [NRM_W-1:0] qx   [1:DIV_BITS];
  logic [NRM_W-1:0] qy   [1:DIV_BITS];
  logic             ovx  [1:DIV_BITS];
  logic             ovy  [1:DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
    localparam int B = DIV_BITS - 1 - j;
    logic             v_in;
    div_side_t        d_in;
    logic [DW-1:0]    rx_in, ry_in, dsh;
    logic [NRM_W-1:0] qx_in, qy_in;
    logic             ox_in, oy_in, gex, gey;

    if (j == 0) begin : g_first
      logic [DW-1:0] top;
      assign v_in       = in_valid;
      assign d_in.side  = in_side;
      assign d_in.dlen  = in_dist;
      assign rx_in      = DW'({in_side.adx, {FRAC_BITS{1'b0}}});
      assign ry_in      = DW'({in_side.ady, {FRAC_BITS{1'b0}}});
      assign qx_in      = '0;
      assign qy_in      = '0;
      // quotient at or above 2^DIV_BITS saturates
      assign top        = DW'(in_dist) << DIV_BITS;
      assign ox_in      = rx_in >= top;
      assign oy_in      = ry_in >= top;
    end else begin : g_next
      assign v_in  = vld[j];
      assign d_in  = dsd[j];
      assign rx_in = remx[j];
      assign ry_in = remy[j];
      assign qx_in = qx[j];
      assign qy_in = qy[j];
      assign ox_in = ovx[j];
      assign oy_in = ovy[j];
    end

    assign dsh = DW'(d_in.dlen) << B;
    assign gex = rx_in >= dsh;
    assign gey = ry_in >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsd[j+1]  <= d_in;
        remx[j+1] <= gex ? rx_in - dsh : rx_in;
        remy[j+1] <= gey ? ry_in - dsh : ry_in;
        qx[j+1]   <= {qx_in[NRM_W-2:0], gex};
        qy[j+1]   <= {qy_in[NRM_W-2:0], gey};
        ovx[j+1]  <= ox_in;
        ovy[j+1]  <= oy_in;
      end
    end
  end

  assign out_valid = vld[DIV_BITS];
  assign out_side  = dsd[DIV_BITS];
  assign out_qx    = qx[DIV_BITS];
  assign out_qy    = qy[DIV_BITS];
  assign out_ovx   = ovx[DIV_BITS];
  assign out_ovy   = ovy[DIV_BITS];

endmodule

FILE: design/bcc_back.sv
`timescale 1ns / 1ps
module bcc_back import bcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  div_side_t               in_side,
  input  logic [NRM_W-1:0]        in_qx,
  input  logic [NRM_W-1:0]        in_qy,
  input  logic                    in_ovx,
  input  logic                    in_ovy,
  output logic                    out_valid,
  output logic                    hit,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic [30:0]             penetration,
  output logic signed [31:0]      contact_x,
  output logic signed [31:0]      contact_y
);

  // Stage A: normal magnitude, sign and penetration
  logic             tiny;
  logic [NRM_W-1:0] mx, my, px_mag, py_mag;
  logic             sa_valid;
  side_t            sa_side;
  logic [NRM_W-1:0] sa_mx, sa_my;
  logic             sa_nx, sa_ny;
  logic [30:0]      sa_pen;

  assign tiny = in_side.dlen < TINY_LIM;
  assign mx   = (in_ovx || in_qx > NRM_SAT) ? NRM_SAT : in_qx;
  assign my   = (in_ovy || in_qy > NRM_SAT) ? NRM_SAT : in_qy;
  // positive side stops one lsb short of 2.0
  assign px_mag = (!in_side.side.negx && mx > NRM_MAX) ? NRM_MAX : mx;
  assign py_mag = (!in_side.side.negy && my > NRM_MAX) ? NRM_MAX : my;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_side <= in_side.side;
      sa_pen  <= in_side.side.rad - in_side.dlen[30:0];
      if (tiny) begin
        sa_mx <= NRM_ONE;
        sa_my <= '0;
        sa_nx <= 1'b0;
        sa_ny <= 1'b0;
      end else begin
        sa_mx <= px_mag;
        sa_my <= py_mag;
        sa_nx <= in_side.side.negx;
        sa_ny <= in_side.side.negy;
      end
    end
  end

  // Stage B: |n| * r
  logic              sb_valid;
  side_t             sb_side;
  logic [NRM_W-1:0]  sb_mx, sb_my;
  logic              sb_nx, sb_ny;
  logic [30:0]       sb_pen;
  logic [PROD_W-1:0] sb_prx, sb_pry;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_side <= sa_side;
      sb_mx   <= sa_mx;
      sb_my   <= sa_my;
      sb_nx   <= sa_nx;
      sb_ny   <= sa_ny;
      sb_pen  <= sa_pen;
      sb_prx  <= sa_mx * sa_side.rad;
      sb_pry  <= sa_my * sa_side.rad;
    end
  end

  // Stage C: contact = closest +/- (|n| * r >> FRAC_BITS), saturated
  logic signed [SUM_W-1:0] offx, offy, basex, basey, sumx, sumy;
  logic signed [31:0]      satx, saty;
  logic signed [NRM_W-1:0] nrmx, nrmy;

  assign offx  = SUM_W'(sb_prx >> FRAC_BITS);
  assign offy  = SUM_W'(sb_pry >> FRAC_BITS);
  assign basex = SUM_W'(sb_side.px);
  assign basey = SUM_W'(sb_side.py);
  assign sumx  = sb_nx ? basex - offx : basex + offx;
  assign sumy  = sb_ny ? basey - offy : basey + offy;
  assign nrmx  = sb_nx ? NRM_W'(-sb_mx) : sb_mx;
  assign nrmy  = sb_ny ? NRM_W'(-sb_my) : sb_my;

  always_comb begin
    if (sumx > SUM_W'(32'sh7fffffff)) begin
      satx = 32'sh7fffffff;
    end else if (sumx < -SUM_W'(33'sh080000000)) begin
      satx = 32'sh80000000;
    end else begin
      satx = sumx[31:0];
    end
    if (sumy > SUM_W'(32'sh7fffffff)) begin
      saty = 32'sh7fffffff;
    end else if (sumy < -SUM_W'(33'sh080000000)) begin
      saty = 32'sh80000000;
    end else begin
      saty = sumy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sb_valid;
    end
  end

  // misses and same-owner pairs show all-zero fields
  always_ff @(posedge clk) begin
    if (en) begin
      hit         <= sb_side.hit;
      normal_x    <= sb_side.hit ? nrmx : '0;
      normal_y    <= sb_side.hit ? nrmy : '0;
      penetration <= sb_side.hit ? sb_pen : '0;
      contact_x   <= sb_side.hit ? satx : '0;
      contact_y   <= sb_side.hit ? saty : '0;
    end
  end

endmodule

FILE: design/box_circle_collision.sv
`timescale 1ns / 1ps
// channel   handshake             payload
// req       req_valid/req_ready   box_x box_y circle_x circle_y circle_radius same_owner
// res       res_valid/res_ready   hit normal_x normal_y penetration contact_x contact_y
// cfg       cfg_we                cfg_index cfg_data (box_width, box_height)
//
// One request per cycle unless stalled; stages: 5 front, 32 square-root
// (one root bit each), 18 divide (one quotient bit each), 3 back.
// Square root and normal divide set the depth; the rate is one per cycle unless stalled.
// Sync reset clears all valid bits; size registers return to 1.0.
// res_ready low with a result held freezes the whole pipe; nothing is lost.
module box_circle_collision import bcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic signed [31:0]      box_x,
  input  logic signed [31:0]      box_y,
  input  logic signed [31:0]      circle_x,
  input  logic signed [31:0]      circle_y,
  input  logic [30:0]             circle_radius,
  input  logic                    same_owner,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    hit,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic [30:0]             penetration,
  output logic signed [31:0]      contact_x,
  output logic signed [31:0]      contact_y,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [CFG_W-1:0] box_width, box_height;
  logic             en;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= CFG_W'(65536);
      box_height <= CFG_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_WIDTH:  box_width  <= cfg_data;
        CFG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances unless a held result is not taken
  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  logic              f_valid;
  logic [SQ_W-1:0]   f_dsq;
  side_t             f_side;
  logic              r_valid;
  logic [DIST_W-1:0] r_root;
  side_t             r_side;
  logic              d_valid;
  div_side_t         d_side;
  logic [NRM_W-1:0]  d_qx, d_qy;
  logic              d_ovx, d_ovy;

  bcc_front u_front (
    .clk, .rst, .en,
    .in_valid (req_valid && req_ready),
    .box_x, .box_y, .circle_x, .circle_y, .circle_radius, .same_owner,
    .box_width, .box_height,
    .out_valid (f_valid),
    .out_dsq   (f_dsq),
    .out_side  (f_side)
  );

  bcc_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_val    (f_dsq),
    .in_side   (f_side),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  bcc_div u_div (
    .clk, .rst, .en,
    .in_valid  (r_valid),
    .in_dist   (r_root),
    .in_side   (r_side),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_ovx   (d_ovx),
    .out_ovy   (d_ovy)
  );

  bcc_back u_back (
    .clk, .rst, .en,
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_qx     (d_qx),
    .in_qy     (d_qy),
    .in_ovx    (d_ovx),
    .in_ovy    (d_ovy),
    .out_valid (res_valid),
    .hit, .normal_x, .normal_y, .penetration, .contact_x, .contact_y
  );

endmodule

FILE: design/bcc_checker.sv
`timescale 1ns / 1ps
`include "box_circle_collision_assert.svh"
module bcc_checker import bcc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic signed [31:0]      box_x,
  input logic signed [31:0]      box_y,
  input logic signed [31:0]      circle_x,
  input logic signed [31:0]      circle_y,
  input logic [30:0]             circle_radius,
  input logic                    same_owner,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic                    hit,
  input logic signed [NRM_W-1:0] normal_x,
  input logic signed [NRM_W-1:0] normal_y,
  input logic [30:0]             penetration,
  input logic signed [31:0]      contact_x,
  input logic signed [31:0]      contact_y,
  input logic                    cfg_we,
  input cfg_idx_t                cfg_index,
  input logic [CFG_W-1:0]        cfg_data
);

  // A miss carries all-zero fields
  `BCC_ASSERT_IMP(a_miss_zero, res_valid && !hit, normal_x == 0 && normal_y == 0 && penetration == 0 && contact_x == 0 && contact_y == 0)

  // A hit always has a nonzero normal
  `BCC_ASSERT_IMP(a_hit_normal, res_valid && hit, normal_x != 0 || normal_y != 0)

  // Requests are refused only while a result waits
  `BCC_ASSERT_IMP(a_ready_stall, !req_ready, res_valid && !res_ready)

  // A held result keeps its hit flag and contact point
  `BCC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(hit) && $stable(contact_x) && $stable(contact_y))

endmodule

bind box_circle_collision bcc_checker u_bcc_checker (.*);
